// ----- hdl/hstr_pkg.sv -----
// Shared types and constants for the half-space triangle rasterizer.
package hstr_pkg;

  // Fixed field widths of the request and result channels and of the internal deltas and edge values.
  localparam int COORD_W   = 15;
  localparam int PIX_OUT_W = 12;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int EDGE_W    = 36;

  // Default configuration of the core.
  localparam int DEF_SCREEN_SIZE   = 2048;
  localparam int DEF_FRACTION_BITS = 4;

  // Request function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Triangle setup sequencer.
  typedef enum logic [2:0] {
    LD_IDLE,
    LD_MINMAX,
    LD_BOX,
    LD_MUL,
    LD_SUM
  } load_state_t;

endpackage

// ----- hdl/halfspace_triangle_rasterizer_core.sv -----
// Half-space triangle rasterizer core: triangle setup and one pixel test per step.
// Each accepted request writes its result into the output register. Throughput: one step
// request per cycle unless setup or a held result stalls; the edge values advance by
// one add per lane per step. A load request stalls the request channel while the setup
// sequencer forms the box, the deltas and the edge products (one multiply stage per lane).
// Reset (synchronous, active high) empties the output register and leaves no triangle loaded.
module halfspace_triangle_rasterizer_core #(
  parameter int SCREEN_SIZE   = hstr_pkg::DEF_SCREEN_SIZE,
  parameter int FRACTION_BITS = hstr_pkg::DEF_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [hstr_pkg::COORD_W-1:0]  ax,
  input  logic [hstr_pkg::COORD_W-1:0]  ay,
  input  logic [hstr_pkg::COORD_W-1:0]  bx,
  input  logic [hstr_pkg::COORD_W-1:0]  by,
  input  logic [hstr_pkg::COORD_W-1:0]  cx,
  input  logic [hstr_pkg::COORD_W-1:0]  cy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          valid_res,
  output logic [hstr_pkg::PIX_OUT_W-1:0] px,
  output logic [hstr_pkg::PIX_OUT_W-1:0] py,
  output logic                          covered,
  output logic                          last
);
  import hstr_pkg::*;

  localparam int PIX_W   = $clog2(SCREEN_SIZE + 1);
  localparam int ONE     = 1 << FRACTION_BITS;
  localparam int RND_W   = COORD_W + 1;
  localparam int RAW_W   = RND_W - FRACTION_BITS;
  localparam int REL_W   = ((PIX_W + FRACTION_BITS > COORD_W) ?
                            (PIX_W + FRACTION_BITS) : COORD_W) + 1;
  localparam int PROD_W  = DELTA_W + REL_W;
  localparam int STEP_W  = DELTA_W + FRACTION_BITS;

  // Rounds a fixed-point coordinate up to a pixel index and clamps it to the screen.
  function automatic logic [PIX_W-1:0] to_pixel(input logic [COORD_W-1:0] coord);
    logic [RND_W-1:0] sum;
    logic [RAW_W-1:0] raw;
    sum = RND_W'(coord) + RND_W'(ONE - 1);
    raw = sum[RND_W-1:FRACTION_BITS];
    if (32'(raw) > 32'(SCREEN_SIZE)) begin
      return PIX_W'(SCREEN_SIZE);
    end
    return PIX_W'(raw);
  endfunction

  // Handshake and sequencer state.
  load_state_t ld_state, ld_state_next;
  logic        accept;
  logic        busy;

  // Setup pipeline registers.
  logic        [COORD_W-1:0] vx [3];
  logic        [COORD_W-1:0] vy [3];
  logic        [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [DELTA_W-1:0] dx [3];
  logic signed [DELTA_W-1:0] dy [3];
  logic                      bias [3];
  logic        [PIX_W-1:0]   box_top;
  logic signed [REL_W-1:0]   rel_x [3];
  logic signed [REL_W-1:0]   rel_y [3];
  logic signed [PROD_W-1:0]  prod_a [3];
  logic signed [PROD_W-1:0]  prod_b [3];

  // Traversal state.
  logic signed [EDGE_W-1:0]  edge_row [3];
  logic signed [EDGE_W-1:0]  edge_col [3];
  logic signed [STEP_W-1:0]  step_per_column [3];
  logic signed [STEP_W-1:0]  step_per_row [3];
  logic        [PIX_W-1:0]   box_left, box_right, box_bottom;
  logic        [PIX_W-1:0]   cur_col, cur_row;
  logic                      active;

  // Step datapath signals.
  logic                      step_go;
  logic        [PIX_W:0]     col_inc, row_inc;
  logic                      wrap;
  logic                      row_done;
  logic                      res_covered;
  logic                      res_last;
  logic        [COORD_W-1:0] min_x_c, max_x_c, min_y_c, max_y_c;
  logic        [PIX_W-1:0]   left_c, top_c;

  // Request handshake: stall while setting up a triangle or when the result is held.
  assign busy     = (ld_state != LD_IDLE);
  assign in_stall = busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Setup sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_state <= LD_IDLE;
    end else begin
      ld_state <= ld_state_next;
    end
  end

  // Setup sequencer next state.
  always_comb begin
    ld_state_next = ld_state;
    case (ld_state)
      LD_IDLE:   if (accept && func == FUNC_LOAD) ld_state_next = LD_MINMAX;
      LD_MINMAX: ld_state_next = LD_BOX;
      LD_BOX:    ld_state_next = LD_MUL;
      LD_MUL:    ld_state_next = LD_SUM;
      LD_SUM:    ld_state_next = LD_IDLE;
      default:   ld_state_next = LD_IDLE;
    endcase
  end

  // Vertex extremes for the bounding box.
  always_comb begin
    min_x_c = (vx[0] < vx[1]) ? vx[0] : vx[1];
    min_x_c = (min_x_c < vx[2]) ? min_x_c : vx[2];
    max_x_c = (vx[0] > vx[1]) ? vx[0] : vx[1];
    max_x_c = (max_x_c > vx[2]) ? max_x_c : vx[2];
    min_y_c = (vy[0] < vy[1]) ? vy[0] : vy[1];
    min_y_c = (min_y_c < vy[2]) ? min_y_c : vy[2];
    max_y_c = (vy[0] > vy[1]) ? vy[0] : vy[1];
    max_y_c = (max_y_c > vy[2]) ? max_y_c : vy[2];
  end

  assign left_c = to_pixel(min_x);
  assign top_c  = to_pixel(min_y);

  // Triangle setup pipeline: one stage per sequencer state.
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_LOAD) begin
      vx[0] <= ax;
      vy[0] <= ay;
      vx[1] <= bx;
      vy[1] <= by;
      vx[2] <= cx;
      vy[2] <= cy;
    end
    if (ld_state == LD_MINMAX) begin
      min_x <= min_x_c;
      max_x <= max_x_c;
      min_y <= min_y_c;
      max_y <= max_y_c;
      for (int i = 0; i < 3; i++) begin
        // Edge i runs from vertex i to the next vertex; the top-left rule sets the bias.
        dx[i] <= $signed(DELTA_W'(vx[i])) - $signed(DELTA_W'(vx[(i == 2) ? 0 : i + 1]));
        dy[i] <= $signed(DELTA_W'(vy[i])) - $signed(DELTA_W'(vy[(i == 2) ? 0 : i + 1]));
        bias[i] <= (vy[i] < vy[(i == 2) ? 0 : i + 1]) ||
                   ((vy[i] == vy[(i == 2) ? 0 : i + 1]) &&
                    (vx[i] > vx[(i == 2) ? 0 : i + 1]));
      end
    end
    if (ld_state == LD_BOX) begin
      box_left   <= left_c;
      box_right  <= to_pixel(max_x);
      box_top    <= top_c;
      box_bottom <= to_pixel(max_y);
      // Vertex position relative to the box origin in fixed point.
      for (int i = 0; i < 3; i++) begin
        rel_x[i] <= $signed(REL_W'(vx[i]) - (REL_W'(left_c) << FRACTION_BITS));
        rel_y[i] <= $signed(REL_W'(vy[i]) - (REL_W'(top_c) << FRACTION_BITS));
      end
    end
    if (ld_state == LD_MUL) begin
      for (int i = 0; i < 3; i++) begin
        prod_a[i] <= dy[i] * rel_x[i];
        prod_b[i] <= dx[i] * rel_y[i];
      end
    end
  end

  // Step datapath: pixel position, coverage test and end-of-box detection.
  assign step_go     = (func == FUNC_STEP) && active;
  assign col_inc     = {1'b0, cur_col} + (PIX_W + 1)'(1);
  assign row_inc     = {1'b0, cur_row} + (PIX_W + 1)'(1);
  assign wrap        = (col_inc >= {1'b0, box_right});
  assign row_done    = (row_inc >= {1'b0, box_bottom});
  assign res_covered = (edge_col[0] > 0) && (edge_col[1] > 0) && (edge_col[2] > 0);
  assign res_last    = (col_inc == {1'b0, box_right}) && (row_inc == {1'b0, box_bottom});

  // Traversal state: written at the end of setup, advanced by each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ld_state == LD_SUM) begin
      active <= (box_left < box_right) && (box_top < box_bottom);
    end else if (accept && step_go && wrap && row_done) begin
      active <= 1'b0;
    end
    if (ld_state == LD_SUM) begin
      for (int i = 0; i < 3; i++) begin
        edge_row[i] <= EDGE_W'(prod_a[i]) - EDGE_W'(prod_b[i]) +
                       $signed(EDGE_W'(bias[i]));
        edge_col[i] <= EDGE_W'(prod_a[i]) - EDGE_W'(prod_b[i]) +
                       $signed(EDGE_W'(bias[i]));
        step_per_column[i] <= STEP_W'(dy[i]) <<< FRACTION_BITS;
        step_per_row[i]    <= STEP_W'(dx[i]) <<< FRACTION_BITS;
      end
      cur_col <= box_left;
      cur_row <= box_top;
    end else if (accept && step_go) begin
      if (wrap) begin
        cur_col <= box_left;
        cur_row <= PIX_W'(row_inc);
        for (int i = 0; i < 3; i++) begin
          edge_row[i] <= edge_row[i] + EDGE_W'(step_per_row[i]);
          edge_col[i] <= edge_row[i] + EDGE_W'(step_per_row[i]);
        end
      end else begin
        cur_col <= PIX_W'(col_inc);
        for (int i = 0; i < 3; i++) begin
          edge_col[i] <= edge_col[i] - EDGE_W'(step_per_column[i]);
        end
      end
    end
  end

  // Output register: filled on every accepted request, drained when not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      valid_res <= step_go;
      px        <= step_go ? PIX_OUT_W'(cur_col) : '0;
      py        <= step_go ? PIX_OUT_W'(cur_row) : '0;
      covered   <= step_go && res_covered;
      last      <= step_go && res_last;
    end
  end

endmodule

// ----- hdl/hstr_check.sv -----
// Port-level assertion checker for the rasterizer core, with its bind statement.
module hstr_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           func,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           valid_res,
  input logic [hstr_pkg::PIX_OUT_W-1:0] px,
  input logic [hstr_pkg::PIX_OUT_W-1:0] py,
  input logic                           covered,
  input logic                           last
);
  import hstr_pkg::*;

  // A held result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(px) &&
      $stable(py) && $stable(covered) && $stable(last))
    else $error("held result changed");

  // An accepted load request stalls the request channel during setup.
  a_load_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_LOAD |=> in_stall)
    else $error("load request not followed by setup stall");

  // An accepted load request answers with an empty result next cycle.
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_LOAD |=> out_valid && !valid_res)
    else $error("load request did not produce an empty result");

  // A result that reports no pixel carries all-zero fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> px == '0 && py == '0 && !covered && !last)
    else $error("empty result carries nonzero fields");

  // The last flag only appears on a visited pixel.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> valid_res)
    else $error("last flag without a visited pixel");

endmodule

bind halfspace_triangle_rasterizer_core hstr_check u_hstr_check (.*);

// ----- tb/sv/tb_halfspace_triangle_rasterizer_core.sv -----
// Self-checking testbench for the half-space triangle rasterizer core.
`timescale 1ns / 1ps

module tb_halfspace_triangle_rasterizer_core;
  import hstr_pkg::*;

  localparam int FRAC        = DEF_FRACTION_BITS;
  localparam longint ONE_PIX = longint'(1) << FRAC;
  localparam int STEP_W      = DELTA_W + FRAC + 1;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int ITEM_TARGET = 800;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic               drain;
    logic               f;
    logic [COORD_W-1:0] x0, y0, x1, y1, x2, y2;
  } raster_cmd_t;

  typedef struct {
    logic                 valid_res;
    logic [PIX_OUT_W-1:0] px;
    logic [PIX_OUT_W-1:0] py;
    logic                 covered;
    logic                 last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_STEP;
  logic [COORD_W-1:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic valid_res;
  logic [PIX_OUT_W-1:0] px, py;
  logic covered, last;

  raster_cmd_t raster_cmd_q[$];
  pixel_t      pixel_result_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  int          items = 0;

  // Predicted rasterizer state.
  logic signed [EDGE_W-1:0] edge_row[3];
  logic signed [EDGE_W-1:0] edge_col[3];
  logic signed [STEP_W-1:0] col_step[3];
  logic signed [STEP_W-1:0] row_step[3];
  logic [PIX_OUT_W-1:0] box_left, box_right, box_bottom, cur_col, cur_row;
  logic                 active;

  halfspace_triangle_rasterizer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .ax        (ax),
    .ay        (ay),
    .bx        (bx),
    .by        (by),
    .cx        (cx),
    .cy        (cy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .px        (px),
    .py        (py),
    .covered   (covered),
    .last      (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint least_of(input longint a, input longint b, input longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint most_of(input longint a, input longint b, input longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Round a fixed-point coordinate up to a whole pixel, clamped to the screen.
  function automatic logic [PIX_OUT_W-1:0] ceil_pixel(input longint coord);
    longint p;
    p = (coord + ONE_PIX - 1) >>> FRAC;
    if (p > DEF_SCREEN_SIZE) p = DEF_SCREEN_SIZE;
    return p[PIX_OUT_W-1:0];
  endfunction

  // Apply one accepted request to the predicted state and queue its result.
  task automatic rasterize_request(input logic f,
                                   input logic [COORD_W-1:0] x0, y0, x1, y1, x2, y2);
    longint vx[3], vy[3];
    longint dx, dy, k, top;
    int i, j;
    pixel_t res;
    res = '{valid_res: 1'b0, px: '0, py: '0, covered: 1'b0, last: 1'b0};
    if (f == FUNC_LOAD) begin
      vx[0] = x0; vy[0] = y0;
      vx[1] = x1; vy[1] = y1;
      vx[2] = x2; vy[2] = y2;
      box_left   = ceil_pixel(least_of(vx[0], vx[1], vx[2]));
      box_right  = ceil_pixel(most_of(vx[0], vx[1], vx[2]));
      top        = ceil_pixel(least_of(vy[0], vy[1], vy[2]));
      box_bottom = ceil_pixel(most_of(vy[0], vy[1], vy[2]));
      for (i = 0; i < 3; i++) begin
        j  = (i + 1) % 3;
        dx = vx[i] - vx[j];
        dy = vy[i] - vy[j];
        k  = dy * vx[i] - dx * vy[i];
        // Top-left fill rule bias.
        if (dy < 0 || (dy == 0 && dx > 0)) k = k + 1;
        k = k + dx * (top << FRAC) - dy * (longint'(box_left) << FRAC);
        edge_row[i] = k[EDGE_W-1:0];
        edge_col[i] = k[EDGE_W-1:0];
        col_step[i] = STEP_W'(dy * ONE_PIX);
        row_step[i] = STEP_W'(dx * ONE_PIX);
      end
      cur_col = box_left;
      cur_row = top[PIX_OUT_W-1:0];
      active  = (longint'(box_left) < longint'(box_right)) && (top < longint'(box_bottom));
    end else if (active) begin
      res.valid_res = 1'b1;
      res.px        = cur_col;
      res.py        = cur_row;
      res.covered   = (edge_col[0] > 0) && (edge_col[1] > 0) && (edge_col[2] > 0);
      res.last      = (cur_col + 1 == box_right) && (cur_row + 1 == box_bottom);
      for (i = 0; i < 3; i++) edge_col[i] = edge_col[i] - col_step[i];
      cur_col = cur_col + 1;
      // Wrap to the start of the next row.
      if (cur_col >= box_right) begin
        cur_col = box_left;
        cur_row = cur_row + 1;
        for (i = 0; i < 3; i++) begin
          edge_row[i] = edge_row[i] + row_step[i];
          edge_col[i] = edge_row[i];
        end
        if (cur_row >= box_bottom) active = 1'b0;
      end
    end
    pixel_result_q.push_back(res);
  endtask

  task automatic add_cmd(input logic f, input int x0, y0, x1, y1, x2, y2);
    raster_cmd_t c;
    c.drain = 1'b0;
    c.f  = f;
    c.x0 = x0[COORD_W-1:0]; c.y0 = y0[COORD_W-1:0];
    c.x1 = x1[COORD_W-1:0]; c.y1 = y1[COORD_W-1:0];
    c.x2 = x2[COORD_W-1:0]; c.y2 = y2[COORD_W-1:0];
    raster_cmd_q.push_back(c);
  endtask

  task automatic add_step();
    add_cmd(FUNC_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
            $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
            $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endtask

  task automatic add_drain();
    raster_cmd_t c;
    c = '{drain: 1'b1, f: FUNC_STEP, x0: '0, y0: '0, x1: '0, y1: '0, x2: '0, y2: '0};
    raster_cmd_q.push_back(c);
  endtask

  // Small triangle anywhere on screen; walk all of its box or only part of it.
  task automatic queue_triangle(input bit full_walk);
    int v[6];
    int base_x, base_y, w, h, n, i, extra;
    base_x = $urandom_range(0, COORD_MAX - 63);
    base_y = $urandom_range(0, COORD_MAX - 63);
    for (i = 0; i < 6; i += 2) begin
      v[i]     = base_x + $urandom_range(0, 63);
      v[i + 1] = base_y + $urandom_range(0, 63);
    end
    w = int'(ceil_pixel(most_of(v[0], v[2], v[4]))) -
        int'(ceil_pixel(least_of(v[0], v[2], v[4])));
    h = int'(ceil_pixel(most_of(v[1], v[3], v[5]))) -
        int'(ceil_pixel(least_of(v[1], v[3], v[5])));
    add_cmd(FUNC_LOAD, v[0], v[1], v[2], v[3], v[4], v[5]);
    n = full_walk ? w * h : $urandom_range(0, w * h);
    // A full walk sometimes runs a step or two past the end of the box.
    extra = (full_walk && $urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n + extra) add_step();
    items += 1 + n + extra;
  endtask

  // Request driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    raster_cmd_t c;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) rasterize_request(func, ax, ay, bx, by, cx, cy);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (raster_cmd_q.size() != 0 && raster_cmd_q[0].drain) begin
          // Hold off until every outstanding result has been taken.
          in_valid <= 1'b0;
          if (pixel_result_q.size() == 0) void'(raster_cmd_q.pop_front());
        end else if (raster_cmd_q.size() != 0) begin
          c = raster_cmd_q.pop_front();
          func     <= c.f;
          ax       <= c.x0;
          ay       <= c.y0;
          bx       <= c.x1;
          by       <= c.y1;
          cx       <= c.x2;
          cy       <= c.y2;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern, with two long hold-offs to back the core up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 400 || rx_cycle == 2000) hold_left = 90;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((rx_cycle / 250) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (rx_cycle % 3 == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_result_q.size() == 0) begin
        $display("%0t: unexpected result px %0d py %0d", $time, px, py);
        mismatches++;
      end else begin
        want = pixel_result_q.pop_front();
        check_field("valid_res", want.valid_res, valid_res);
        check_field("px", want.px, px);
        check_field("py", want.py, py);
        check_field("covered", want.covered, covered);
        check_field("last", want.last, last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int n;
    // Directed: step with nothing loaded, degenerate boxes at both extremes.
    add_step();
    add_cmd(FUNC_LOAD, 0, 0, 0, 0, 0, 0);
    add_step();
    add_cmd(FUNC_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_step();
    // Right triangle with a horizontal and a vertical edge, 3x3 box, one step past the end.
    add_cmd(FUNC_LOAD, 16, 16, 64, 16, 16, 64);
    repeat (10) add_step();
    // Opposite winding, abandoned after two pixels by a new load.
    add_cmd(FUNC_LOAD, 33, 40, 20, 60, 60, 20);
    repeat (2) add_step();
    // Single pixel box with the flat edge going left.
    add_cmd(FUNC_LOAD, 110, 96, 96, 96, 96, 110);
    add_step();
    // Let the core run dry once before the random part.
    add_drain();
    items = 21;

    // Random part: mostly complete walks, plus abandoned walks, huge boxes and noise.
    while (items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        queue_triangle(1'b1);
      end else if (r < 75) begin
        queue_triangle(1'b0);
      end else if (r < 88) begin
        add_cmd(FUNC_LOAD, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        n = $urandom_range(0, 6);
        repeat (n) add_step();
        items += 1 + n;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) add_step();
        items += n;
      end
      if ($urandom_range(0, 49) == 0) add_drain();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (raster_cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (pixel_result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- halfspace_triangle_rasterizer_core.f -----
hdl/hstr_pkg.sv
hdl/halfspace_triangle_rasterizer_core.sv
hdl/hstr_check.sv
tb/sv/tb_halfspace_triangle_rasterizer_core.sv
